[hw/rtl/fra_pkg.sv]
// Shared types and constants for the fragment reassembler.
package fra_pkg;

  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int unsigned MAX_FRAG     = 256;
  localparam int unsigned FRAG_AW      = $clog2(MAX_FRAG);
  localparam int unsigned IDX_W        = FRAG_AW + 1;
  localparam int unsigned BANK_AW      = FRAG_AW + 1;
  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_FRAG  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_REJECTED  = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_ACCEPTED  = 2'd2;
  localparam logic [1:0] ST_COMPLETE  = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [7:0] FLAG_START = 8'h01;
  localparam logic [7:0] FLAG_END   = 8'h02;

  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(BUFFER_BYTES);
  localparam logic [7:0]       VER_RESET = 8'd1;

  typedef enum logic [1:0] {BK_IDLE, BK_COPY, BK_FIN} bk_state_e;

  // one unit of work handed from front to back
  typedef struct packed {
    logic               is_read;
    logic               copy;
    logic [1:0]         status;
    logic [LEN_W-1:0]   deliv;
    logic               bank;
    logic [LEN_W-1:0]   off;
    logic [IDX_W-1:0]   plen;
    logic [BUF_AW-1:0]  addr;
  } qent_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         data;
  } bank_wr_t;

endpackage

[hw/rtl/fragment_reassembler_unit.sv]
// Top level of the fragment reassembler: config registers and unit wiring.
//
//  channel  dir  handshake          payload
//  s_axis   in   tvalid/tready      tuser=func, tlast=last, tdata=data_byte,read_address
//  m_axis   out  tvalid/tready      tuser=kind, tdata=status,delivered_length,read_data
//  apb      in   psel/penable       0x0 capacity, 0x4 expected_version
//
// Fragment bytes and reads are taken one per cycle. An accepted fragment's payload
// is copied into the frame buffer by the back end at one byte per cycle; reads queued
// behind a copy wait for it. Input stalls when the queue is full or when the next
// fragment would overwrite a bank still being copied. Reset clears all control state;
// buffer contents are undefined until written.
module fragment_reassembler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [19:8] read_address, zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] status, [14:2] delivered_length, [22:15] read_data
  output logic        m_axis_tuser,   // [0] kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [fra_pkg::LEN_W-1:0]    cap_q;
  logic [7:0]                   ver_q;
  fra_pkg::bank_wr_t            bank_wr;
  logic [fra_pkg::BANK_AW-1:0]  prev_addr, cp_addr;
  logic [7:0]                   prev_data, cp_data;
  logic                         cp_en;
  logic                         push, q_ready, q_valid, pop;
  fra_pkg::qent_t               push_ent, head;
  fra_pkg::done_t               done;
  logic [1:0]                   status;
  logic [fra_pkg::LEN_W-1:0]    deliv;
  logic [7:0]                   rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, ver_q} : {19'd0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= fra_pkg::CAP_RESET;
      ver_q <= fra_pkg::VER_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        ver_q <= pwdata[7:0];
      end else begin
        cap_q <= pwdata[fra_pkg::LEN_W-1:0];
      end
    end
  end

  fra_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .func_i         (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .last_i         (s_axis_tlast),
    .read_address_i (s_axis_tdata[19:8]),
    .capacity_i     (cap_q),
    .exp_ver_i      (ver_q),
    .bank_wr_o      (bank_wr),
    .prev_addr_o    (prev_addr),
    .prev_data_i    (prev_data),
    .push_o         (push),
    .push_ent_o     (push_ent),
    .q_ready_i      (q_ready),
    .done_i         (done)
  );

  fra_banks u_banks (
    .clk_i     (clk_i),
    .wr_i      (bank_wr),
    .ra_addr_i (prev_addr),
    .ra_data_o (prev_data),
    .rb_en_i   (cp_en),
    .rb_addr_i (cp_addr),
    .rb_data_o (cp_data)
  );

  fra_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_i      (pop),
    .head_o     (head)
  );

  fra_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_head_i           (head),
    .q_pop_o            (pop),
    .bank_rd_en_o       (cp_en),
    .bank_rd_addr_o     (cp_addr),
    .bank_rd_data_i     (cp_data),
    .done_o             (done),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .kind_o             (m_axis_tuser),
    .status_o           (status),
    .delivered_length_o (deliv),
    .read_data_o        (rdata)
  );

  assign m_axis_tdata = {1'b0, rdata, deliv, status};

endmodule

[hw/rtl/fra_banks.sv]
// Fragment bank memory: two banks, one write port, two registered read ports.
module fra_banks (
  input  logic                          clk_i,
  input  fra_pkg::bank_wr_t             wr_i,
  input  logic [fra_pkg::BANK_AW-1:0]   ra_addr_i,
  output logic [7:0]                    ra_data_o,
  input  logic                          rb_en_i,
  input  logic [fra_pkg::BANK_AW-1:0]   rb_addr_i,
  output logic [7:0]                    rb_data_o
);

  logic [7:0] mem [2*fra_pkg::MAX_FRAG];
  logic [7:0] ra_q;
  logic [7:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    ra_q <= mem[ra_addr_i];
    if (rb_en_i) begin
      rb_q <= mem[rb_addr_i];
    end
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

[hw/rtl/fra_queue.sv]
// Short work queue between front and back.
module fra_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fra_pkg::qent_t push_ent_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output fra_pkg::qent_t head_o
);

  fra_pkg::qent_t                  ent_q [fra_pkg::QUEUE_DEPTH];
  logic [fra_pkg::QPTR_W-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [fra_pkg::QPTR_W:0]        cnt_q, cnt_d;

  assign ready_o = cnt_q != (fra_pkg::QPTR_W+1)'(fra_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_ent_i;
    end
  end

endmodule

[hw/rtl/fra_front.sv]
// Front: collects fragment bytes, compares with the previous fragment, judges.
module fra_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_i,
  input  logic [fra_pkg::BUF_AW-1:0]        read_address_i,
  input  logic [fra_pkg::LEN_W-1:0]         capacity_i,
  input  logic [7:0]                        exp_ver_i,
  output fra_pkg::bank_wr_t                 bank_wr_o,
  output logic [fra_pkg::BANK_AW-1:0]       prev_addr_o,
  input  logic [7:0]                        prev_data_i,
  output logic                              push_o,
  output fra_pkg::qent_t                    push_ent_o,
  input  logic                              q_ready_i,
  input  fra_pkg::done_t                    done_i
);

  localparam int unsigned IW = fra_pkg::IDX_W;
  localparam int unsigned LW = fra_pkg::LEN_W;

  logic [IW-1:0]  idx_q, idx_d;
  logic           too_long_q, too_long_d;
  logic [63:0]    hdr_q, hdr_d;
  logic           differs_q, differs_d;
  logic [IW-1:0]  prev_len_q, prev_len_d;
  logic           bank_q, bank_d;
  logic           started_q, started_d;
  logic           complete_q, complete_d;
  logic           failed_q, failed_d;
  logic [15:0]    ident_q, ident_d;
  logic [LW-1:0]  flen_q, flen_d;
  logic [LW-1:0]  noff_q, noff_d;
  logic [1:0]     pend_q, pend_d;

  logic           acc;
  logic           tl_eff, dif_eff;
  logic [IW-1:0]  len;
  logic [63:0]    hdr_eff;
  logic [7:0]     ver, flags;
  logic [15:0]    fid, total, off;
  logic [IW-1:0]  plen;
  logic [16:0]    sum;
  logic           fills, endf, bad;
  logic [LW-1:0]  cap;
  logic [LW-1:0]  new_len;
  logic [LW:0]    end_off;

  assign in_ready_o  = q_ready_i && !pend_q[bank_q];
  assign acc         = in_valid_i && in_ready_o;
  assign prev_addr_o = {~bank_d, idx_d[fra_pkg::FRAG_AW-1:0]};

  assign ver   = hdr_eff[7:0];
  assign flags = hdr_eff[15:8];
  assign fid   = hdr_eff[31:16];
  assign total = hdr_eff[47:32];
  assign off   = hdr_eff[63:48];
  assign plen  = len - IW'(fra_pkg::HDR_BYTES);
  assign sum   = {1'b0, off} + 17'(plen);
  assign fills = sum >= {1'b0, total};
  assign endf  = (flags & fra_pkg::FLAG_END) != 8'd0;
  assign bad   = ver != exp_ver_i || (flags & ~(fra_pkg::FLAG_START | fra_pkg::FLAG_END)) != 8'd0
              || fid == 16'd0 || total == 16'd0 || (fills && sum != {1'b0, total})
              || endf != fills;
  assign cap     = (capacity_i > LW'(fra_pkg::BUFFER_BYTES)) ? LW'(fra_pkg::BUFFER_BYTES)
                                                             : capacity_i;
  assign new_len = started_q ? flen_q : total[LW-1:0];
  assign end_off = {1'b0, noff_q} + (LW+1)'(plen);

  always_comb begin
    idx_d      = idx_q;
    too_long_d = too_long_q;
    hdr_d      = hdr_q;
    differs_d  = differs_q;
    prev_len_d = prev_len_q;
    bank_d     = bank_q;
    started_d  = started_q;
    complete_d = complete_q;
    failed_d   = failed_q;
    ident_d    = ident_q;
    flen_d     = flen_q;
    noff_d     = noff_q;
    pend_d     = pend_q;
    bank_wr_o  = '0;
    push_o     = 1'b0;
    push_ent_o = '0;
    tl_eff     = too_long_q;
    dif_eff    = differs_q;
    len        = idx_q;
    hdr_eff    = hdr_q;

    if (done_i.valid) begin
      pend_d[done_i.bank] = 1'b0;
    end

    if (acc && func_i == fra_pkg::FUNC_FRAG) begin
      if (idx_q >= IW'(fra_pkg::MAX_FRAG)) begin
        tl_eff = 1'b1;
      end else begin
        bank_wr_o.en   = 1'b1;
        bank_wr_o.addr = {bank_q, idx_q[fra_pkg::FRAG_AW-1:0]};
        bank_wr_o.data = data_byte_i;
        len     = idx_q + 1'b1;
        dif_eff = differs_q || idx_q >= prev_len_q || prev_data_i != data_byte_i;
        if (idx_q < IW'(fra_pkg::HDR_BYTES)) begin
          hdr_eff[idx_q[2:0]*8 +: 8] = data_byte_i;
        end
      end
      if (!last_i) begin
        idx_d      = len;
        too_long_d = tl_eff;
        hdr_d      = hdr_eff;
        differs_d  = dif_eff;
      end else begin
        idx_d      = '0;
        too_long_d = 1'b0;
        hdr_d      = '0;
        differs_d  = 1'b0;
        push_o     = 1'b1;
        push_ent_o.is_read = 1'b0;
        push_ent_o.status  = fra_pkg::ST_REJECTED;
        if (failed_q || complete_q) begin
          push_ent_o.status = fra_pkg::ST_REJECTED;
        end else if (tl_eff || len < IW'(fra_pkg::HDR_BYTES + 1)) begin
          failed_d = 1'b1;
        end else if (bad) begin
          failed_d = 1'b1;
        end else if (started_q && len == prev_len_q && !dif_eff) begin
          push_ent_o.status = fra_pkg::ST_DUPLICATE;
        end else if (!started_q && ((flags & fra_pkg::FLAG_START) == 8'd0 || off != 16'd0
                                    || total > {3'b0, cap})) begin
          failed_d = 1'b1;
        end else if (started_q && ((flags & fra_pkg::FLAG_START) != 8'd0 || fid != ident_q
                                   || total != {3'b0, flen_q} || off != {3'b0, noff_q})) begin
          failed_d = 1'b1;
        end else if (end_off > {1'b0, new_len}) begin
          failed_d = 1'b1;
        end else begin
          if (!started_q) begin
            ident_d   = fid;
            flen_d    = new_len;
            started_d = 1'b1;
          end
          push_ent_o.copy = 1'b1;
          push_ent_o.bank = bank_q;
          push_ent_o.off  = noff_q;
          push_ent_o.plen = plen;
          pend_d[bank_q]  = 1'b1;
          noff_d     = end_off[LW-1:0];
          prev_len_d = len;
          bank_d     = ~bank_q;
          if (endf) begin
            complete_d        = 1'b1;
            push_ent_o.status = fra_pkg::ST_COMPLETE;
            push_ent_o.deliv  = new_len;
          end else begin
            push_ent_o.status = fra_pkg::ST_ACCEPTED;
          end
        end
      end
    end else if (acc && func_i == fra_pkg::FUNC_READ) begin
      push_o             = 1'b1;
      push_ent_o.is_read = 1'b1;
      push_ent_o.addr    = read_address_i;
    end else if (acc && func_i == fra_pkg::FUNC_CLEAR) begin
      idx_d      = '0;
      too_long_d = 1'b0;
      hdr_d      = '0;
      differs_d  = 1'b0;
      bank_d     = 1'b0;
      prev_len_d = '0;
      started_d  = 1'b0;
      complete_d = 1'b0;
      failed_d   = 1'b0;
      ident_d    = '0;
      flen_d     = '0;
      noff_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      too_long_q <= 1'b0;
      hdr_q      <= '0;
      differs_q  <= 1'b0;
      prev_len_q <= '0;
      bank_q     <= 1'b0;
      started_q  <= 1'b0;
      complete_q <= 1'b0;
      failed_q   <= 1'b0;
      ident_q    <= '0;
      flen_q     <= '0;
      noff_q     <= '0;
      pend_q     <= '0;
    end else begin
      idx_q      <= idx_d;
      too_long_q <= too_long_d;
      hdr_q      <= hdr_d;
      differs_q  <= differs_d;
      prev_len_q <= prev_len_d;
      bank_q     <= bank_d;
      started_q  <= started_d;
      complete_q <= complete_d;
      failed_q   <= failed_d;
      ident_q    <= ident_d;
      flen_q     <= flen_d;
      noff_q     <= noff_d;
      pend_q     <= pend_d;
    end
  end

endmodule

[hw/rtl/fra_back.sv]
// Back: copies accepted payload into the frame buffer, serves reads, drives results.
module fra_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  fra_pkg::qent_t                q_head_i,
  output logic                          q_pop_o,
  output logic                          bank_rd_en_o,
  output logic [fra_pkg::BANK_AW-1:0]   bank_rd_addr_o,
  input  logic [7:0]                    bank_rd_data_i,
  output fra_pkg::done_t                done_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [1:0]                    status_o,
  output logic [fra_pkg::LEN_W-1:0]     delivered_length_o,
  output logic [7:0]                    read_data_o
);

  localparam int unsigned AW = fra_pkg::BUF_AW;

  logic [7:0] fb [fra_pkg::BUFFER_BYTES];
  logic [7:0] fb_rdata_q;

  fra_pkg::bk_state_e           state_q, state_d;
  fra_pkg::qent_t               ent_q, ent_d;
  logic [fra_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic                         rv_q, rv_d;
  logic [AW-1:0]                waddr_q, waddr_d;
  logic                         fb_rd_en;

  logic                         s1_v_q, s1_v_d;
  logic                         s1_kind_q, s1_kind_d;
  logic [1:0]                   s1_st_q, s1_st_d;
  logic [fra_pkg::LEN_W-1:0]    s1_len_q, s1_len_d;

  logic                         out_v_q;
  logic                         out_kind_q;
  logic [1:0]                   out_st_q;
  logic [fra_pkg::LEN_W-1:0]    out_len_q;
  logic [7:0]                   out_data_q;
  logic                         out_load, s1_free;
  logic [fra_pkg::FRAG_AW-1:0]  rd_off;

  assign out_load = s1_v_q && (!out_v_q || out_ready_i);
  assign s1_free  = !s1_v_q || out_load;
  assign rd_off   = fra_pkg::FRAG_AW'(fra_pkg::HDR_BYTES) + cnt_q[fra_pkg::FRAG_AW-1:0];

  always_comb begin
    state_d        = state_q;
    ent_d          = ent_q;
    cnt_d          = cnt_q;
    rv_d           = 1'b0;
    waddr_d        = waddr_q;
    fb_rd_en       = 1'b0;
    q_pop_o        = 1'b0;
    bank_rd_en_o   = 1'b0;
    bank_rd_addr_o = {ent_q.bank, rd_off};
    done_o         = '0;
    s1_v_d         = out_load ? 1'b0 : s1_v_q;
    s1_kind_d      = s1_kind_q;
    s1_st_d        = s1_st_q;
    s1_len_d       = s1_len_q;
    case (state_q)
      fra_pkg::BK_IDLE: begin
        if (q_valid_i && s1_free) begin
          q_pop_o = 1'b1;
          if (q_head_i.is_read) begin
            fb_rd_en  = 1'b1;
            s1_v_d    = 1'b1;
            s1_kind_d = fra_pkg::KIND_READ;
            s1_st_d   = 2'd0;
            s1_len_d  = '0;
          end else if (q_head_i.copy) begin
            ent_d   = q_head_i;
            cnt_d   = '0;
            state_d = fra_pkg::BK_COPY;
          end else begin
            s1_v_d    = 1'b1;
            s1_kind_d = fra_pkg::KIND_STATUS;
            s1_st_d   = q_head_i.status;
            s1_len_d  = q_head_i.deliv;
          end
        end
      end
      fra_pkg::BK_COPY: begin
        // read a bank byte, write it to the frame buffer in the next cycle
        if (cnt_q < ent_q.plen) begin
          bank_rd_en_o = 1'b1;
          rv_d         = 1'b1;
          waddr_d      = AW'(ent_q.off + fra_pkg::LEN_W'(cnt_q));
          cnt_d        = cnt_q + 1'b1;
        end else if (!rv_q) begin
          state_d = fra_pkg::BK_FIN;
        end
      end
      fra_pkg::BK_FIN: begin
        if (s1_free) begin
          s1_v_d      = 1'b1;
          s1_kind_d   = fra_pkg::KIND_STATUS;
          s1_st_d     = ent_q.status;
          s1_len_d    = ent_q.deliv;
          done_o.valid = 1'b1;
          done_o.bank  = ent_q.bank;
          state_d     = fra_pkg::BK_IDLE;
        end
      end
      default: state_d = fra_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      fb[waddr_q] <= bank_rd_data_i;
    end
    if (fb_rd_en) begin
      fb_rdata_q <= fb[q_head_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fra_pkg::BK_IDLE;
      rv_q    <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      s1_v_q  <= s1_v_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    cnt_q     <= cnt_d;
    waddr_q   <= waddr_d;
    s1_kind_q <= s1_kind_d;
    s1_st_q   <= s1_st_d;
    s1_len_q  <= s1_len_d;
    if (out_load) begin
      out_kind_q <= s1_kind_q;
      out_st_q   <= s1_st_q;
      out_len_q  <= s1_len_q;
      out_data_q <= (s1_kind_q == fra_pkg::KIND_READ) ? fb_rdata_q : 8'd0;
    end
  end

  assign out_valid_o        = out_v_q;
  assign kind_o             = out_kind_q;
  assign status_o           = out_st_q;
  assign delivered_length_o = out_len_q;
  assign read_data_o        = out_data_q;

endmodule

[bench/tb_fragment_reassembler_unit.sv]
// Testbench for fragment_reassembler_unit: random fragment streams checked by a scoreboard.
`timescale 1ns / 100ps

module tb_fragment_reassembler_unit;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 300;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic       kind;
    logic [1:0] status;
    logic [12:0] deliv;
    logic [7:0] rdata;
  } reasm_result_t;

  class reassembly_scoreboard;
    reasm_result_t result_q[$];
    int errors;
    logic [7:0] frame_mem[fra_pkg::BUFFER_BYTES];
    logic [7:0] bank_mem[2*fra_pkg::MAX_FRAG];
    int unsigned written_top;
    logic bank_sel, too_long, differs, started, complete, failed;
    logic [63:0] hdr;
    int unsigned byte_idx, prev_len, cur_ident, frame_len, next_off;
    int unsigned capacity, version;

    function new();
      errors = 0;
      written_top = 0;
      capacity = fra_pkg::BUFFER_BYTES;
      version = 1;
      clear_frame();
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      if (idx == 0) capacity = v[12:0];
      else version = v[7:0];
    endfunction

    function void drop_partial();
      byte_idx = 0;
      too_long = 0;
      hdr = '0;
      differs = 0;
    endfunction

    function void clear_frame();
      drop_partial();
      bank_sel = 0;
      prev_len = 0;
      started = 0;
      complete = 0;
      failed = 0;
      cur_ident = 0;
      frame_len = 0;
      next_off = 0;
    endfunction

    function void collect(logic [7:0] b);
      int unsigned cur, prv;
      cur = bank_sel ? fra_pkg::MAX_FRAG : 0;
      prv = bank_sel ? 0 : fra_pkg::MAX_FRAG;
      if (byte_idx >= fra_pkg::MAX_FRAG) begin
        too_long = 1;
        return;
      end
      if (byte_idx < fra_pkg::HDR_BYTES) hdr[8*byte_idx +: 8] = b;
      bank_mem[cur + byte_idx] = b;
      if (byte_idx >= prev_len || bank_mem[prv + byte_idx] != b) differs = 1;
      byte_idx++;
    endfunction

    function logic [1:0] judge_fragment(output int unsigned deliv);
      int unsigned ver, flags, fid, total, off, plen, cap, cur;
      logic last_frag, fills;
      deliv = 0;
      if (failed || complete) return fra_pkg::ST_REJECTED;
      if (too_long || byte_idx < fra_pkg::HDR_BYTES + 1) begin
        failed = 1;
        return fra_pkg::ST_REJECTED;
      end
      ver = hdr[7:0];
      flags = hdr[15:8];
      fid = hdr[31:16];
      total = hdr[47:32];
      off = hdr[63:48];
      plen = byte_idx - fra_pkg::HDR_BYTES;
      last_frag = (flags & fra_pkg::FLAG_END) != 0;
      fills = off + plen >= total;
      if (ver != version || (flags & ~(fra_pkg::FLAG_START | fra_pkg::FLAG_END)) != 0 ||
          fid == 0 || total == 0 || (fills && off + plen != total) || last_frag != fills) begin
        failed = 1;
        return fra_pkg::ST_REJECTED;
      end
      if (started && byte_idx == prev_len && !differs) return fra_pkg::ST_DUPLICATE;
      if (!started) begin
        cap = capacity > fra_pkg::BUFFER_BYTES ? fra_pkg::BUFFER_BYTES : capacity;
        if ((flags & fra_pkg::FLAG_START) == 0 || off != 0 || total > cap) begin
          failed = 1;
          return fra_pkg::ST_REJECTED;
        end
        cur_ident = fid;
        frame_len = total;
        started = 1;
      end else if ((flags & fra_pkg::FLAG_START) != 0 || fid != cur_ident ||
                   total != frame_len || off != next_off) begin
        failed = 1;
        return fra_pkg::ST_REJECTED;
      end
      if (next_off + plen > frame_len) begin
        failed = 1;
        return fra_pkg::ST_REJECTED;
      end
      cur = bank_sel ? fra_pkg::MAX_FRAG : 0;
      for (int unsigned i = 0; i < plen; i++)
        if (next_off + i < fra_pkg::BUFFER_BYTES)
          frame_mem[next_off + i] = bank_mem[cur + fra_pkg::HDR_BYTES + i];
      next_off += plen;
      if (next_off > written_top) written_top = next_off;
      prev_len = byte_idx;
      bank_sel = ~bank_sel;
      if (last_frag) begin
        complete = 1;
        deliv = frame_len;
        return fra_pkg::ST_COMPLETE;
      end
      return fra_pkg::ST_ACCEPTED;
    endfunction

    function void note_input(logic [1:0] func, logic [7:0] b, logic last, logic [11:0] addr);
      reasm_result_t r;
      int unsigned d;
      r = '{fra_pkg::KIND_STATUS, 2'd0, 13'd0, 8'd0};
      if (func == fra_pkg::FUNC_FRAG) begin
        collect(b);
        if (!last) return;
        r.status = judge_fragment(d);
        r.deliv = 13'(d);
        drop_partial();
        result_q.push_back(r);
      end else if (func == fra_pkg::FUNC_READ) begin
        r.kind = fra_pkg::KIND_READ;
        r.rdata = frame_mem[addr];
        result_q.push_back(r);
      end else if (func == fra_pkg::FUNC_CLEAR) begin
        clear_frame();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic kind, logic [1:0] st, logic [12:0] dl, logic [7:0] rd);
      reasm_result_t e;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d status=%0d", kind, st));
        return;
      end
      e = result_q.pop_front();
      if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
      if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
      if (dl !== e.deliv) report($sformatf("length %0d, want %0d", dl, e.deliv));
      if (rd !== e.rdata) report($sformatf("read data %0h, want %0h", rd, e.rdata));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] data_byte, [19:8] read_address, zero fill
  logic [1:0]  s_axis_tuser = '0;  // [1:0] func
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;       // [1:0] status, [14:2] length, [22:15] read_data
  logic        m_axis_tuser;       // [0] kind
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reassembly_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit hold_done = 0;
  int unsigned cur_ver = 1;

  fragment_reassembler_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[14:2], m_axis_tdata[22:15]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      sb.report("no item accepted before the watchdog limit");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off to back the block up
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent > 40) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // tvalid stays up between back-to-back items; drain() drops it
  task automatic send_item(logic [1:0] func, logic [7:0] b, logic last, logic [11:0] addr);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= func;
    s_axis_tdata <= {4'd0, addr, b};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(func, b, last, addr);
    if (func != FUNC_SPARE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fragment(logic [7:0] bytes[$]);
    foreach (bytes[i])
      send_item(fra_pkg::FUNC_FRAG, bytes[i], i == bytes.size() - 1, 12'($urandom()));
  endtask

  task automatic read_back();
    if (sb.written_top > 0)
      send_item(fra_pkg::FUNC_READ, 8'($urandom()), 1'($urandom()),
                12'($urandom_range(0, sb.written_top - 1)));
  endtask

  // well-formed in-order fragments with occasional header damage and repeats
  task automatic run_frame(int unsigned total, int unsigned maxp, int damage_pct);
    logic [7:0] frag[$];
    int unsigned fid, off, plen;
    logic [7:0] flags;
    fid = $urandom_range(1, 16'hffff);
    off = 0;
    while (off < total) begin
      plen = $urandom_range(1, (total - off) < maxp ? total - off : maxp);
      flags = (off == 0 ? fra_pkg::FLAG_START : 8'h00) |
              (off + plen == total ? fra_pkg::FLAG_END : 8'h00);
      frag = {cur_ver[7:0], flags, fid[7:0], fid[15:8], total[7:0], total[15:8],
              off[7:0], off[15:8]};
      repeat (plen) frag.push_back(8'($urandom()));
      if ($urandom_range(0, 99) < damage_pct)
        frag[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
      send_fragment(frag);
      if ($urandom_range(0, 5) == 0) send_fragment(frag);
      if ($urandom_range(0, 3) == 0) read_back();
      off += plen;
    end
  endtask

  task automatic send_noise(int unsigned len);
    logic [7:0] frag[$];
    repeat (len) frag.push_back(8'($urandom()));
    send_fragment(frag);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(int'(addr[2]), data);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_phase(int unsigned cap, int unsigned ver);
    drain();
    apb_write(3'd0, cap);
    apb_write(3'd4, ver);
    cur_ver = ver;
  endtask

  task automatic random_mix(int target);
    int unsigned pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        run_frame($urandom_range(1, 40), $urandom_range(4, 16), 8);
        if ($urandom_range(0, 4) != 0)
          send_item(fra_pkg::FUNC_CLEAR, 8'($urandom()), 1'($urandom()), 12'($urandom()));
      end else if (pick == 6)
        send_item(fra_pkg::FUNC_CLEAR, 8'($urandom()), 1'($urandom()), 12'($urandom()));
      else if (pick == 7) send_noise($urandom_range(1, 12));
      else if (pick == 8) read_back();
      else send_item(FUNC_SPARE, 8'($urandom()), 1'($urandom()), 12'($urandom()));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    set_phase(fra_pkg::BUFFER_BYTES, 1);

    // directed: one-fragment frame with extreme payload bytes, then latch cases
    send_fragment({8'h01, 8'h03, 8'h34, 8'h12, 8'h05, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'hff, 8'h5a, 8'ha5, 8'h80});
    send_item(fra_pkg::FUNC_READ, 8'h00, 1'b0, 12'd0);
    send_item(fra_pkg::FUNC_READ, 8'hff, 1'b1, 12'd4);
    send_fragment({8'h01, 8'h03, 8'h34, 8'h12, 8'h01, 8'h00, 8'h00, 8'h00, 8'h77});
    send_item(FUNC_SPARE, 8'hff, 1'b1, 12'hfff);
    send_item(fra_pkg::FUNC_CLEAR, 8'h00, 1'b0, 12'd0);
    send_noise(8);
    send_item(fra_pkg::FUNC_CLEAR, 8'hff, 1'b1, 12'hfff);

    set_phase(0, 0);
    // read burst while the receiver holds off, so the result path fills up
    repeat (16) read_back();
    random_mix(100);
    set_phase(8191, 255);
    // oversize fragment
    send_noise(260);
    send_item(fra_pkg::FUNC_CLEAR, 8'h00, 1'b0, 12'd0);
    random_mix(370);
    set_phase(64, 1);
    random_mix(385);
    set_phase(fra_pkg::BUFFER_BYTES, 8'h5a);
    random_mix(400);
    quiet = 1;
    random_mix(415);

    drain();
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
